FILE: rtl/hrlp_pkg.sv
// Shared types, character constants and lookup functions for the request line parser.
package hrlp_pkg;

  // Character codes
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_QUERY = 8'h3F;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  // Token lengths
  localparam logic [1:0] METHOD_LEN  = 2'd3;
  localparam logic [3:0] VERSION_LEN = 4'd8;
  localparam logic [3:0] INDEX_LEN   = 4'd10;

  // Token phases, phase saturation and space count limits
  localparam logic [1:0] PHASE_LAST    = 2'd3;
  localparam logic [1:0] PHASE_METHOD  = 2'd0;
  localparam logic [1:0] PHASE_TARGET  = 2'd1;
  localparam logic [1:0] PHASE_VERSION = 2'd2;
  localparam logic [1:0] SPACES_MAX    = 2'd3;
  localparam logic [1:0] SPACES_WANTED = 2'd2;

  // Verdict status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_MALFORMED = 2'd1;
  localparam logic [1:0] STATUS_VERSION   = 2'd2;

  // Result kinds
  localparam logic KIND_TARGET  = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Command queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] line_byte;
    logic       end_of_line;
  } line_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] target_char;
    logic [1:0] parse_status;
    logic       method_is_get;
    logic       http_minor;
    logic       run_last;
  } result_item_t;

  // Work for one input byte, handed from front to back
  typedef struct packed {
    logic       has_index;
    logic       has_char;
    logic [7:0] char_byte;
    logic       has_verdict;
    logic [1:0] parse_status;
    logic       method_is_get;
    logic       http_minor;
  } cmd_t;

  // "GET"
  function automatic logic [7:0] method_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = 8'h47; // G
      2'd1:    c = 8'h45; // E
      default: c = 8'h54; // T
    endcase
    return c;
  endfunction

  // "HTTP/1.x", the last character picked by minor
  function automatic logic [7:0] version_char(input logic [2:0] idx, input logic minor);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h48; // H
      3'd1:    c = 8'h54; // T
      3'd2:    c = 8'h54; // T
      3'd3:    c = 8'h50; // P
      3'd4:    c = 8'h2F; // /
      3'd5:    c = 8'h31; // 1
      3'd6:    c = 8'h2E; // .
      default: c = minor ? 8'h31 : 8'h30;
    endcase
    return c;
  endfunction

  // "index.html"
  function automatic logic [7:0] index_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h69; // i
      4'd1:    c = 8'h6E; // n
      4'd2:    c = 8'h64; // d
      4'd3:    c = 8'h65; // e
      4'd4:    c = 8'h78; // x
      4'd5:    c = 8'h2E; // .
      4'd6:    c = 8'h68; // h
      4'd7:    c = 8'h74; // t
      4'd8:    c = 8'h6D; // m
      4'd9:    c = 8'h6C; // l
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/http_request_line_parser.sv
// Request line parser: one input byte per cycle while the command queue is not full,
// results held in an output register. A result passes through the command queue and
// then the output register. Each output slot carries one result, so a byte that yields
// "index.html" emits ten target results (plus a verdict if it ends the line), and a final
// target byte emits two. A four-entry command queue absorbs those bursts before stalling.
// Synchronous reset clears token state, the queue and the output valid.
module http_request_line_parser import hrlp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         line_valid,
  output logic         line_stall,
  input  line_item_t   line_item,
  output logic         result_valid,
  input  logic         result_stall,
  output result_item_t result_item
);

  logic queue_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  hrlp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .line_valid (line_valid),
    .line_stall (line_stall),
    .line_item  (line_item),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  hrlp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  hrlp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_cmd     (head_cmd),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule

FILE: rtl/hrlp_front.sv
// Front end: accepts line bytes, tracks token state and issues per-byte commands.
module hrlp_front import hrlp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       line_valid,
  output logic       line_stall,
  input  line_item_t line_item,
  input  logic       queue_full,
  output logic       push,
  output cmd_t       push_cmd
);

  logic [1:0] token_phase, token_phase_next;
  logic [1:0] space_total, space_total_next;
  logic       previous_was_space, previous_was_space_next;
  logic       spacing_error, spacing_error_next;
  logic       at_line_start, at_line_start_next;
  logic [1:0] method_position, method_position_next;
  logic       method_mismatch, method_mismatch_next;
  logic       target_is_root, target_is_root_next;
  logic       query_seen, query_seen_next;
  logic [3:0] version_position, version_position_next;
  logic       matches_one_one, matches_one_one_next;
  logic       matches_one_zero, matches_one_zero_next;

  logic       accept;
  logic       is_sp;
  logic       last;
  logic [7:0] b;
  logic       ok11, ok10;
  cmd_t       cmd;

  assign line_stall = queue_full;
  assign accept     = line_valid && !queue_full;
  assign b          = line_item.line_byte;
  assign last       = line_item.end_of_line;
  assign is_sp      = (b == CHAR_SPACE);

  // Classify the byte and compute next token state
  always_comb begin
    token_phase_next        = token_phase;
    space_total_next        = space_total;
    spacing_error_next      = spacing_error;
    method_position_next    = method_position;
    method_mismatch_next    = method_mismatch;
    target_is_root_next     = target_is_root;
    query_seen_next         = query_seen;
    version_position_next   = version_position;
    matches_one_one_next    = matches_one_one;
    matches_one_zero_next   = matches_one_zero;
    previous_was_space_next = is_sp;
    at_line_start_next      = 1'b0;
    cmd                     = '0;
    ok11                    = 1'b0;
    ok10                    = 1'b0;

    if (is_sp && (previous_was_space || at_line_start)) begin
      spacing_error_next = 1'b1;
    end
    if (is_sp && !last && space_total != SPACES_MAX) begin
      space_total_next = space_total + 2'd1;
    end

    if (is_sp) begin
      // A space closing a bare "/" target triggers the index rewrite
      if (token_phase == PHASE_TARGET && target_is_root) begin
        cmd.has_index = 1'b1;
      end
      if (token_phase != PHASE_LAST) begin
        token_phase_next = token_phase + 2'd1;
      end
    end else begin
      unique case (token_phase)
        PHASE_METHOD: begin
          if (method_position == METHOD_LEN || b != method_char(method_position)) begin
            method_mismatch_next = 1'b1;
          end
          if (method_position != METHOD_LEN) begin
            method_position_next = method_position + 2'd1;
          end
        end
        PHASE_TARGET: begin
          target_is_root_next = previous_was_space && (b == CHAR_SLASH);
          if (b == CHAR_QUERY) begin
            query_seen_next = 1'b1;
          end else if (!query_seen) begin
            cmd.has_char  = 1'b1;
            cmd.char_byte = b;
          end
        end
        PHASE_VERSION: begin
          if (version_position != VERSION_LEN) begin
            if (b != version_char(version_position[2:0], 1'b1)) begin
              matches_one_one_next = 1'b0;
            end
            if (b != version_char(version_position[2:0], 1'b0)) begin
              matches_one_zero_next = 1'b0;
            end
            version_position_next = version_position + 4'd1;
          end
        end
        default: begin
        end
      endcase
    end

    // Build the verdict on the last byte and rearm for the next line
    if (last) begin
      cmd.has_verdict = 1'b1;
      ok11 = matches_one_one_next && (version_position_next == VERSION_LEN);
      ok10 = matches_one_zero_next && (version_position_next == VERSION_LEN);
      if (spacing_error_next || space_total_next != SPACES_WANTED) begin
        cmd.parse_status = STATUS_MALFORMED;
      end else begin
        cmd.method_is_get = !method_mismatch_next && (method_position_next == METHOD_LEN);
        if (ok11) begin
          cmd.parse_status = STATUS_OK;
          cmd.http_minor   = 1'b1;
        end else if (ok10) begin
          cmd.parse_status = STATUS_OK;
        end else begin
          cmd.parse_status = STATUS_VERSION;
        end
      end
      token_phase_next        = PHASE_METHOD;
      space_total_next        = 2'd0;
      previous_was_space_next = 1'b0;
      spacing_error_next      = 1'b0;
      at_line_start_next      = 1'b1;
      method_position_next    = 2'd0;
      method_mismatch_next    = 1'b0;
      target_is_root_next     = 1'b0;
      query_seen_next         = 1'b0;
      version_position_next   = 4'd0;
      matches_one_one_next    = 1'b1;
      matches_one_zero_next   = 1'b1;
    end
  end

  assign push     = accept && (cmd.has_index || cmd.has_char || cmd.has_verdict);
  assign push_cmd = cmd;

  // Advance token state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      token_phase        <= PHASE_METHOD;
      space_total        <= 2'd0;
      previous_was_space <= 1'b0;
      spacing_error      <= 1'b0;
      at_line_start      <= 1'b1;
      method_position    <= 2'd0;
      method_mismatch    <= 1'b0;
      target_is_root     <= 1'b0;
      query_seen         <= 1'b0;
      version_position   <= 4'd0;
      matches_one_one    <= 1'b1;
      matches_one_zero   <= 1'b1;
    end else if (accept) begin
      token_phase        <= token_phase_next;
      space_total        <= space_total_next;
      previous_was_space <= previous_was_space_next;
      spacing_error      <= spacing_error_next;
      at_line_start      <= at_line_start_next;
      method_position    <= method_position_next;
      method_mismatch    <= method_mismatch_next;
      target_is_root     <= target_is_root_next;
      query_seen         <= query_seen_next;
      version_position   <= version_position_next;
      matches_one_one    <= matches_one_one_next;
      matches_one_zero   <= matches_one_zero_next;
    end
  end

endmodule

FILE: rtl/hrlp_queue.sv
// Short command queue between the front end and the result sequencer.
module hrlp_queue import hrlp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full       = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (QUEUE_AW+1)'(1);
        2'b01:   count <= count - (QUEUE_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("command pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && !head_valid))
    else $error("command popped from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");
`endif

endmodule

FILE: rtl/hrlp_back.sv
// Back end: expands queued commands into result items through an output register.
module hrlp_back import hrlp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         head_valid,
  input  cmd_t         head_cmd,
  output logic         pop,
  output logic         result_valid,
  input  logic         result_stall,
  output result_item_t result_item
);

  logic [3:0]   pos;
  logic [3:0]   byte_count;
  logic [3:0]   piece_count;
  logic         is_byte_piece;
  logic         last_piece;
  logic         load;
  result_item_t piece;

  // Count the pieces of the head command
  assign byte_count    = head_cmd.has_index ? INDEX_LEN : {3'd0, head_cmd.has_char};
  assign piece_count   = byte_count + {3'd0, head_cmd.has_verdict};
  assign is_byte_piece = (pos < byte_count);
  assign last_piece    = (pos == piece_count - 4'd1);

  assign load = head_valid && (!result_valid || !result_stall);
  assign pop  = load && last_piece;

  // Form the current result piece
  always_comb begin
    piece = '0;
    if (is_byte_piece) begin
      piece.result_kind = KIND_TARGET;
      piece.target_char = head_cmd.has_index ? index_char(pos) : head_cmd.char_byte;
    end else begin
      piece.result_kind   = KIND_VERDICT;
      piece.parse_status  = head_cmd.parse_status;
      piece.method_is_get = head_cmd.method_is_get;
      piece.http_minor    = head_cmd.http_minor;
    end
    piece.run_last = last_piece;
  end

  // Step through pieces and hold the output register under stall
  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= 4'd0;
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        pos          <= last_piece ? 4'd0 : pos + 4'd1;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_item <= piece;
    end
  end

`ifndef SYNTH
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (pos < piece_count))
    else $error("piece position beyond command length");
  a_pos_rewinds: assert property (@(posedge clk) disable iff (rst) pop |=> (pos == 4'd0))
    else $error("piece position not rewound after pop");
  a_verdict_closes: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_item.result_kind == KIND_VERDICT) |-> result_item.run_last)
    else $error("verdict not marked as last result");
`endif

endmodule
